>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands. The clock is i_clk and the reset is i_rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every edge outside reset.
`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg
// Shared constants, codes and types of the sorted priority queue.
// ---------------------------------------------------------------------------
package spq_pkg;

    localparam int SPQ_DEPTH = 16;

    localparam int ID_W   = 16;
    localparam int PRIO_W = 8;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

>>> rtl/core/spq_ctrl.sv
// ---------------------------------------------------------------------------
// spq_ctrl
// Two-state sequencer: latches a beat, runs the update state, then strobes.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module spq_ctrl
    import spq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    output t_dp_cmd o_cmd,
    output logic    o_valid
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_done;

    assign busy       = (r_state == S_EXEC);
    assign o_cmd.load = start && !busy;
    assign o_cmd.exec = (r_state == S_EXEC);
    assign o_valid    = r_done;

    always_comb begin
        case (r_state)
            S_IDLE:  n_state = start ? S_EXEC : S_IDLE;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= o_cmd.exec;
        end
    end

    `ASSERT_IMPLY(a_done_after_exec, r_done, $past(r_state == S_EXEC))
    `ASSERT_NEXT(a_exec_one_cycle, r_state == S_EXEC, r_state == S_IDLE)
    `ASSERT_IMPLY(a_load_when_idle, o_cmd.load, r_state == S_IDLE)

endmodule

>>> rtl/core/spq_dp.sv
// ---------------------------------------------------------------------------
// spq_dp
// Sorted slot array with parallel compare and shift, count and result regs.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module spq_dp
    import spq_pkg::*;
#(
    parameter int DEPTH = SPQ_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic              i_opcode,
    input  logic [ID_W-1:0]   i_job_id,
    input  logic [PRIO_W-1:0] i_job_priority,
    output logic [STAT_W-1:0] o_status,
    output logic [ID_W-1:0]   o_out_id,
    output logic [PRIO_W-1:0] o_out_priority,
    output logic [OCC_W-1:0]  o_occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic              r_op;
    logic [ID_W-1:0]   r_id_in;
    logic [PRIO_W-1:0] r_pri_in;

    logic [ID_W-1:0]   r_ids   [DEPTH];
    logic [PRIO_W-1:0] r_prios [DEPTH];
    logic [ID_W-1:0]   n_ids   [DEPTH];
    logic [PRIO_W-1:0] n_prios [DEPTH];
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    logic [STAT_W-1:0] r_status;
    logic [STAT_W-1:0] n_status;
    logic [ID_W-1:0]   r_out_id;
    logic [ID_W-1:0]   n_out_id;
    logic [PRIO_W-1:0] r_out_prio;
    logic [PRIO_W-1:0] n_out_prio;

    logic [DEPTH-1:0]  w_at_or_after;
    logic              w_full;
    logic              w_empty;

    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    // slot is at or behind the insert point (monotonic over the array)
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_at_or_after[i] = (CNT_W'(i) >= r_count) || (r_prios[i] <= r_pri_in);
        end
    end

    always_comb begin
        n_ids      = r_ids;
        n_prios    = r_prios;
        n_count    = r_count;
        n_status   = ST_OK;
        n_out_id   = '0;
        n_out_prio = '0;
        if (r_op == OP_INSERT) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                if (w_at_or_after[0]) begin
                    n_ids[0]   = r_id_in;
                    n_prios[0] = r_pri_in;
                end
                for (int i = 1; i < DEPTH; i++) begin
                    if (w_at_or_after[i] && !w_at_or_after[i-1]) begin
                        n_ids[i]   = r_id_in;
                        n_prios[i] = r_pri_in;
                    end else if (w_at_or_after[i]) begin
                        n_ids[i]   = r_ids[i-1];
                        n_prios[i] = r_prios[i-1];
                    end
                end
                n_count = r_count + 1'b1;
            end
        end else begin
            if (w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_out_id   = r_ids[0];
                n_out_prio = r_prios[0];
                for (int i = 0; i < DEPTH - 1; i++) begin
                    n_ids[i]   = r_ids[i+1];
                    n_prios[i] = r_prios[i+1];
                end
                n_count = r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_opcode;
            r_id_in  <= i_job_id;
            r_pri_in <= i_job_priority;
        end
        if (i_cmd.exec) begin
            r_ids      <= n_ids;
            r_prios    <= n_prios;
            r_status   <= n_status;
            r_out_id   <= n_out_id;
            r_out_prio <= n_out_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    assign o_status       = r_status;
    assign o_out_id       = r_out_id;
    assign o_out_priority = r_out_prio;
    assign o_occupancy    = OCC_W'(r_count);

    `ASSERT_ALWAYS(a_count_range, r_count <= CNT_W'(DEPTH))
    `ASSERT_NEXT(a_full_holds, i_cmd.exec && r_op == OP_INSERT && w_full,
        r_status == ST_FULL && $stable(r_count))
    `ASSERT_NEXT(a_remove_head, i_cmd.exec && r_op == OP_REMOVE && !w_empty,
        r_out_prio == $past(r_prios[0]) && r_count == $past(r_count) - 1'b1)

endmodule

>>> rtl/core/sorted_priority_queue_top.sv
// ---------------------------------------------------------------------------
// sorted_priority_queue_top
// Priority queue of jobs held in a sorted slot array, head = highest priority.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: drive start with i_opcode, i_job_id, i_job_priority;
//   the beat is taken at an edge where start is high and busy is low.
//   Opcode insert places the job ahead of all slots with priority <= its own
//   (equal priorities served newest first); opcode remove pops the head.
//   Result channel: o_valid pulses for one cycle with o_status, o_out_id,
//   o_out_priority and o_occupancy; the receiver cannot stall it.
//   The beat is latched at the accepting edge; slots and results are written
//   at the end of the update, and o_valid is registered from the update state.
//   busy is high for the single update cycle in which all slots compare in
//   parallel and shift; no command is taken meanwhile. A new command may be
//   taken in the same cycle its predecessor's result is on the ports.
//   Reset (synchronous, active low) empties the queue; slot contents are
//   not cleared, only slots below the count are ever read.
// ---------------------------------------------------------------------------
module sorted_priority_queue_top
    import spq_pkg::*;
#(
    parameter int DEPTH = SPQ_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_opcode,
    input  logic [ID_W-1:0]   i_job_id,
    input  logic [PRIO_W-1:0] i_job_priority,
    output logic              o_valid,
    output logic [STAT_W-1:0] o_status,
    output logic [ID_W-1:0]   o_out_id,
    output logic [PRIO_W-1:0] o_out_priority,
    output logic [OCC_W-1:0]  o_occupancy
);

    t_dp_cmd w_cmd;

    spq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (w_cmd),
        .o_valid (o_valid)
    );

    spq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_opcode       (i_opcode),
        .i_job_id       (i_job_id),
        .i_job_priority (i_job_priority),
        .o_status       (o_status),
        .o_out_id       (o_out_id),
        .o_out_priority (o_out_priority),
        .o_occupancy    (o_occupancy)
    );

endmodule
